// File: sv/setq_pkg.sv
// Package for the sorted expiry timer queue: sizes, transaction payload types,
// action codes, microcode word layout and the microcode ROM.
// No dependencies; used by sorted_expiry_timer_queue_unit.
package setq_pkg;

  localparam int NUM_TIMERS  = 8;
  localparam int MAX_RESULTS = 8;
  localparam int ID_W        = 3;
  localparam int TICK_W      = 32;
  localparam int PERIOD_W    = 16;
  localparam int POS_W       = $clog2(NUM_TIMERS);
  localparam int CNT_W       = $clog2(NUM_TIMERS + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS);
  localparam int UPC_W       = 4;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_START_ABS = 2'd1,
    ACT_START_REL = 2'd2,
    ACT_STOP      = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [ID_W-1:0]     timer_id;
    logic [TICK_W-1:0]   tick_value;
  } in_item_t;

  typedef struct packed {
    logic                fired;
    logic [ID_W-1:0]     expired_id;
    logic [TICK_W-1:0]   now_count;
    logic [PERIOD_W-1:0] next_compare;
    logic                compare_armed;
    logic                last;
  } out_item_t;

  // Datapath operation selected by one microcode word.
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_TICK,
    UOP_EVAL,
    UOP_POP,
    UOP_EMIT_FIRE,
    UOP_EMIT_IDLE,
    UOP_LOAD,
    UOP_SCAN_DROP,
    UOP_REWIND,
    UOP_SCAN_INS,
    UOP_INSERT
  } uop_t;

  // Jump condition, evaluated on the state before the operation takes effect.
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_HIT,
    CND_MORE_FIRE,
    CND_NOT_QUEUED,
    CND_SCAN_MORE,
    CND_FULL,
    CND_INS_MORE
  } cond_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    logic  rd_head;  // read the expiry of the head slot instead of the scan slot
    logic  fin;      // end of program when the jump is not taken
    upc_t  target;
  } ctl_word_t;

  // Program entry points and jump targets.
  localparam upc_t UPC_TICK      = 4'd0;
  localparam upc_t UPC_POP       = 4'd2;
  localparam upc_t UPC_EMIT_IDLE = 4'd5;
  localparam upc_t UPC_START     = 4'd6;
  localparam upc_t UPC_DROP_S    = 4'd7;
  localparam upc_t UPC_PREP_INS  = 4'd8;
  localparam upc_t UPC_SCAN_INS  = 4'd9;
  localparam upc_t UPC_EVAL_END  = 4'd11;
  localparam upc_t UPC_STOP      = 4'd12;
  localparam upc_t UPC_DROP_P    = 4'd13;

  function automatic ctl_word_t mk_cw(input uop_t u, input cond_t c, input logic rh,
                                      input logic f, input upc_t t);
    ctl_word_t w;
    w.uop     = u;
    w.cond    = c;
    w.rd_head = rh;
    w.fin     = f;
    w.target  = t;
    return w;
  endfunction

  function automatic ctl_word_t ucode_rom(input upc_t addr);
    ctl_word_t w;
    unique case (addr)
      // Tick: advance the count, then pop and report expired heads, or report that none expired.
      4'd0:    w = mk_cw(UOP_TICK,      CND_NEVER,      1'b1, 1'b0, UPC_TICK);
      4'd1:    w = mk_cw(UOP_EVAL,      CND_NO_HIT,     1'b1, 1'b0, UPC_EMIT_IDLE);
      4'd2:    w = mk_cw(UOP_POP,       CND_NEVER,      1'b1, 1'b0, UPC_TICK);
      4'd3:    w = mk_cw(UOP_EVAL,      CND_NEVER,      1'b1, 1'b0, UPC_TICK);
      4'd4:    w = mk_cw(UOP_EMIT_FIRE, CND_MORE_FIRE,  1'b1, 1'b1, UPC_POP);
      4'd5:    w = mk_cw(UOP_EMIT_IDLE, CND_NEVER,      1'b1, 1'b1, UPC_TICK);
      // Start: drop the slot if queued, then find its place and insert it if the queue has room.
      4'd6:    w = mk_cw(UOP_LOAD,      CND_NOT_QUEUED, 1'b1, 1'b0, UPC_PREP_INS);
      4'd7:    w = mk_cw(UOP_SCAN_DROP, CND_SCAN_MORE,  1'b0, 1'b0, UPC_DROP_S);
      4'd8:    w = mk_cw(UOP_REWIND,    CND_FULL,       1'b1, 1'b0, UPC_EVAL_END);
      4'd9:    w = mk_cw(UOP_SCAN_INS,  CND_INS_MORE,   1'b0, 1'b0, UPC_SCAN_INS);
      4'd10:   w = mk_cw(UOP_INSERT,    CND_NEVER,      1'b0, 1'b0, UPC_TICK);
      4'd11:   w = mk_cw(UOP_EVAL,      CND_ALWAYS,     1'b1, 1'b0, UPC_EMIT_IDLE);
      // Stop: drop the slot if queued.
      4'd12:   w = mk_cw(UOP_REWIND,    CND_NOT_QUEUED, 1'b1, 1'b0, UPC_EVAL_END);
      4'd13:   w = mk_cw(UOP_SCAN_DROP, CND_SCAN_MORE,  1'b0, 1'b0, UPC_DROP_P);
      4'd14:   w = mk_cw(UOP_NOP,       CND_ALWAYS,     1'b1, 1'b0, UPC_EVAL_END);
      default: w = mk_cw(UOP_NOP,       CND_NEVER,      1'b1, 1'b1, UPC_TICK);
    endcase
    return w;
  endfunction

endpackage

// File: sv/sorted_expiry_timer_queue_unit.sv
// Sorted expiry timer queue: tick counter, expiry-ordered slot queue and a
// microcoded sequencer that runs each action. Depends on setq_pkg.

// Each input transaction runs a short microprogram, one control word per
// clock unless a report finds the output register still full, and the block
// takes no new transaction until that program has handed over its final
// result. A tick advances the count and evaluates the head, then pops,
// re-evaluates and reports each expired timer, or reports once if none has.
// A start drops the slot if already queued, scans for the insert position,
// inserts it if the queue has room, then evaluates and reports; a stop drops
// the slot if queued, then evaluates and reports. The queue scans visit one
// entry per cycle. Every result comes from an output register, so the last
// result of one transaction may wait while the next transaction is accepted.
// The compare period may be written whenever the block is idle and takes
// effect on the next transaction.
module sorted_expiry_timer_queue_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  setq_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output setq_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [setq_pkg::PERIOD_W-1:0]     cfg_wdata
);

  localparam int N = setq_pkg::NUM_TIMERS;

  // Control state.
  logic                              busy_r, busy_nxt;
  setq_pkg::upc_t                    upc_r, upc_nxt;
  logic [setq_pkg::TICK_W-1:0]       tick_r, tick_nxt;
  logic [setq_pkg::CNT_W-1:0]        len_r, len_nxt;
  logic [setq_pkg::CNT_W-1:0]        p_r, p_nxt;
  logic [setq_pkg::NRES_W-1:0]       n_r, n_nxt;
  logic [N-1:0]                      queued_r, queued_nxt;
  logic [setq_pkg::PERIOD_W-1:0]     period_r, period_nxt;
  logic                              out_valid_r, out_valid_nxt;

  // Payload and scratch registers.
  setq_pkg::in_item_t                item_r, item_nxt;
  setq_pkg::out_item_t               out_data_r, out_data_nxt;
  logic [setq_pkg::ID_W-1:0]         fid_r, fid_nxt;
  logic [setq_pkg::TICK_W-1:0]       x_r, x_nxt;
  logic [setq_pkg::PERIOD_W-1:0]     cmp_r, cmp_nxt;
  logic                              armed_r, armed_nxt;
  logic                              hit_r, hit_nxt;
  logic [setq_pkg::ID_W-1:0]         ord_r   [N];
  logic [setq_pkg::ID_W-1:0]         ord_nxt [N];
  logic [setq_pkg::TICK_W-1:0]       exp_r   [N];
  logic                              exp_we;

  setq_pkg::ctl_word_t               cw;
  logic [setq_pkg::ID_W-1:0]         ord_p;
  logic [setq_pkg::ID_W-1:0]         rd_slot;
  logic [setq_pkg::TICK_W-1:0]       exp_rd;
  logic [setq_pkg::TICK_W-1:0]       d_head;
  logic [setq_pkg::TICK_W-1:0]       nd_head;
  logic [setq_pkg::TICK_W-1:0]       ins_diff;
  logic                              p_in;
  logic                              has_head;
  logic                              eval_armed;
  logic                              eval_hit;
  logic                              last_fire;
  logic                              is_emit;
  logic                              exec;
  logic                              take;
  logic                              accept;
  setq_pkg::upc_t                    entry;

  assign cw       = setq_pkg::ucode_rom(upc_r);
  assign ord_p    = ord_r[p_r[setq_pkg::POS_W-1:0]];
  assign rd_slot  = cw.rd_head ? ord_r[0] : ord_p;
  assign exp_rd   = exp_r[rd_slot];
  assign d_head   = exp_rd - tick_r;
  assign nd_head  = tick_r - exp_rd;
  assign ins_diff = x_r - exp_rd;
  assign p_in     = p_r < len_r;
  assign has_head = len_r != '0;

  // Head distance counts only when it is not behind now and below the period.
  assign eval_armed = has_head && (d_head[31:16] == '0) && (d_head[15:0] < period_r);
  assign eval_hit   = has_head && !nd_head[setq_pkg::TICK_W-1];
  assign last_fire  = !hit_r || (n_r == setq_pkg::NRES_W'(setq_pkg::MAX_RESULTS - 1));

  assign is_emit = (cw.uop == setq_pkg::UOP_EMIT_FIRE) || (cw.uop == setq_pkg::UOP_EMIT_IDLE);
  assign exec    = busy_r && !(is_emit && out_valid_r && !out_ready);
  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;

  always_comb begin
    unique case (in_data.action)
      setq_pkg::ACT_TICK: entry = setq_pkg::UPC_TICK;
      setq_pkg::ACT_STOP: begin
        entry = (int'(in_data.timer_id) < N) ? setq_pkg::UPC_STOP : setq_pkg::UPC_EVAL_END;
      end
      default: begin
        entry = (int'(in_data.timer_id) < N) ? setq_pkg::UPC_START : setq_pkg::UPC_EVAL_END;
      end
    endcase
  end

  always_comb begin
    unique case (cw.cond)
      setq_pkg::CND_NEVER:      take = 1'b0;
      setq_pkg::CND_ALWAYS:     take = 1'b1;
      setq_pkg::CND_NO_HIT:     take = !eval_hit;
      setq_pkg::CND_MORE_FIRE:  take = !last_fire;
      setq_pkg::CND_NOT_QUEUED: take = !queued_r[item_r.timer_id];
      setq_pkg::CND_SCAN_MORE:  take = p_in && (ord_p != item_r.timer_id);
      setq_pkg::CND_FULL:       take = len_r >= setq_pkg::CNT_W'(N);
      setq_pkg::CND_INS_MORE:   take = p_in && !ins_diff[setq_pkg::TICK_W-1];
      default:                  take = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    upc_nxt       = upc_r;
    tick_nxt      = tick_r;
    len_nxt       = len_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    queued_nxt    = queued_r;
    period_nxt    = period_r;
    out_valid_nxt = out_valid_r;
    item_nxt      = item_r;
    out_data_nxt  = out_data_r;
    fid_nxt       = fid_r;
    x_nxt         = x_r;
    cmp_nxt       = cmp_r;
    armed_nxt     = armed_r;
    hit_nxt       = hit_r;
    exp_we        = 1'b0;
    for (int i = 0; i < N; i++) begin
      ord_nxt[i] = ord_r[i];
    end

    if (cfg_we) begin
      period_nxt = cfg_wdata;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      item_nxt = in_data;
      upc_nxt  = entry;
      busy_nxt = 1'b1;
    end

    if (exec) begin
      case (cw.uop)
        setq_pkg::UOP_TICK: begin
          tick_nxt = tick_r + 1'b1;
          n_nxt    = '0;
          p_nxt    = '0;
        end
        setq_pkg::UOP_EVAL: begin
          armed_nxt = eval_armed;
          cmp_nxt   = eval_armed ? d_head[setq_pkg::PERIOD_W-1:0] : period_r;
          hit_nxt   = eval_hit;
        end
        setq_pkg::UOP_POP: begin
          fid_nxt           = ord_p;
          queued_nxt[ord_p] = 1'b0;
          len_nxt           = len_r - 1'b1;
          for (int i = 0; i < N - 1; i++) begin
            if (setq_pkg::CNT_W'(i) >= p_r) begin
              ord_nxt[i] = ord_r[i + 1];
            end
          end
        end
        setq_pkg::UOP_EMIT_FIRE: begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.fired         = 1'b1;
          out_data_nxt.expired_id    = fid_r;
          out_data_nxt.now_count     = tick_r;
          out_data_nxt.next_compare  = cmp_r;
          out_data_nxt.compare_armed = armed_r;
          out_data_nxt.last          = last_fire;
          n_nxt                      = n_r + 1'b1;
        end
        setq_pkg::UOP_EMIT_IDLE: begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.fired         = 1'b0;
          out_data_nxt.expired_id    = '0;
          out_data_nxt.now_count     = tick_r;
          out_data_nxt.next_compare  = cmp_r;
          out_data_nxt.compare_armed = armed_r;
          out_data_nxt.last          = 1'b1;
        end
        setq_pkg::UOP_LOAD: begin
          x_nxt = (item_r.action == setq_pkg::ACT_START_ABS) ? item_r.tick_value
                                                             : tick_r + item_r.tick_value;
          p_nxt = '0;
        end
        setq_pkg::UOP_SCAN_DROP: begin
          if (!p_in) begin
            queued_nxt[item_r.timer_id] = 1'b0;
          end else if (ord_p == item_r.timer_id) begin
            queued_nxt[item_r.timer_id] = 1'b0;
            len_nxt                     = len_r - 1'b1;
            for (int i = 0; i < N - 1; i++) begin
              if (setq_pkg::CNT_W'(i) >= p_r) begin
                ord_nxt[i] = ord_r[i + 1];
              end
            end
          end else begin
            p_nxt = p_r + 1'b1;
          end
        end
        setq_pkg::UOP_REWIND: begin
          p_nxt = '0;
        end
        setq_pkg::UOP_SCAN_INS: begin
          if (take) begin
            p_nxt = p_r + 1'b1;
          end
        end
        setq_pkg::UOP_INSERT: begin
          // A new expiry goes after every equal one: the scan stopped past them.
          for (int i = 1; i < N; i++) begin
            if (setq_pkg::CNT_W'(i) > p_r) begin
              ord_nxt[i] = ord_r[i - 1];
            end
          end
          ord_nxt[p_r[setq_pkg::POS_W-1:0]] = item_r.timer_id;
          queued_nxt[item_r.timer_id]       = 1'b1;
          len_nxt                           = len_r + 1'b1;
          exp_we                            = 1'b1;
        end
        default: begin
        end
      endcase

      if (take) begin
        upc_nxt = cw.target;
      end else if (cw.fin) begin
        busy_nxt = 1'b0;
      end else begin
        upc_nxt = upc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      upc_r       <= setq_pkg::UPC_TICK;
      tick_r      <= '0;
      len_r       <= '0;
      p_r         <= '0;
      n_r         <= '0;
      queued_r    <= '0;
      period_r    <= '1;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      upc_r       <= upc_nxt;
      tick_r      <= tick_nxt;
      len_r       <= len_nxt;
      p_r         <= p_nxt;
      n_r         <= n_nxt;
      queued_r    <= queued_nxt;
      period_r    <= period_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
    fid_r      <= fid_nxt;
    x_r        <= x_nxt;
    cmp_r      <= cmp_nxt;
    armed_r    <= armed_nxt;
    hit_r      <= hit_nxt;
    for (int i = 0; i < N; i++) begin
      ord_r[i] <= ord_nxt[i];
    end
  end

  // Slot expiry store, written only when a slot is inserted.
  always_ff @(posedge clk) begin
    if (exp_we) begin
      exp_r[item_r.timer_id] <= x_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= setq_pkg::CNT_W'(N))
    else $error("queue length exceeds the number of slots");

  a_len_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == int'(len_r))
    else $error("queued slot flags disagree with the queue length");

  a_open_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.last) |-> busy_r)
    else $error("a non-final result is pending but the sequencer has finished");

  a_finish_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> (out_valid_r && out_data_r.last))
    else $error("sequencer finished without presenting a final result");

endmodule

// File: test/timer_queue_checker.sv
// Checker for the sorted expiry timer queue: predicts every result from the
// accepted transactions and compares it with what the block hands out.
// Depends on setq_pkg for the payload types, action codes and sizes.
`timescale 1ns / 100ps

module timer_queue_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  setq_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  setq_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [setq_pkg::PERIOD_W-1:0] cfg_wdata,
  output int                            mismatch_count,
  output int                            results_owed
);
  import setq_pkg::*;

  // Predicted copy of the block state.
  logic [TICK_W-1:0]   tick_now;
  logic [ID_W-1:0]     queue_ids [NUM_TIMERS];
  int                  queue_len;
  logic [TICK_W-1:0]   slot_exp [NUM_TIMERS];
  logic                slot_busy [NUM_TIMERS];
  logic [PERIOD_W-1:0] period;

  out_item_t expected_results [$];
  int        errors = 0;

  task automatic remove_slot(input logic [ID_W-1:0] id);
    int pos;
    if (slot_busy[id]) begin
      pos = 0;
      while (pos < queue_len && queue_ids[pos] != id) pos++;
      if (pos < queue_len) begin
        for (int i = pos; i < queue_len - 1; i++) queue_ids[i] = queue_ids[i + 1];
        queue_len--;
      end
      slot_busy[id] = 1'b0;
    end
  endtask

  task automatic insert_slot(input logic [ID_W-1:0] id, input logic [TICK_W-1:0] expiry);
    int                pos;
    logic [TICK_W-1:0] diff;
    remove_slot(id);
    if (queue_len < NUM_TIMERS) begin
      pos = 0;
      // Walk past every entry that expires no later than the new one.
      while (pos < queue_len) begin
        diff = expiry - slot_exp[queue_ids[pos]];
        if (diff[TICK_W-1]) break;
        pos++;
      end
      for (int i = queue_len; i > pos; i--) queue_ids[i] = queue_ids[i - 1];
      queue_ids[pos] = id;
      queue_len++;
      slot_exp[id] = expiry;
      slot_busy[id] = 1'b1;
    end
  endtask

  function automatic out_item_t snapshot(input logic fired, input logic [ID_W-1:0] id);
    out_item_t         r;
    logic [TICK_W-1:0] gap;
    r.fired         = fired;
    r.expired_id    = fired ? id : '0;
    r.now_count     = tick_now;
    r.next_compare  = period;
    r.compare_armed = 1'b0;
    r.last          = 1'b0;
    if (queue_len > 0) begin
      gap = slot_exp[queue_ids[0]] - tick_now;
      if (!gap[TICK_W-1] && gap < {{(TICK_W-PERIOD_W){1'b0}}, period}) begin
        r.next_compare  = gap[PERIOD_W-1:0];
        r.compare_armed = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic predict_action(input in_item_t item);
    out_item_t         batch [MAX_RESULTS];
    int                n;
    logic              hunting;
    logic [ID_W-1:0]   head;
    logic [TICK_W-1:0] late;
    n = 0;
    case (item.action)
      ACT_TICK: begin
        tick_now = tick_now + 1'b1;
        hunting = 1'b1;
        while (hunting && n < MAX_RESULTS && queue_len > 0) begin
          head = queue_ids[0];
          late = tick_now - slot_exp[head];
          if (late[TICK_W-1]) begin
            hunting = 1'b0;
          end else begin
            remove_slot(head);
            batch[n] = snapshot(1'b1, head);
            n++;
          end
        end
      end
      ACT_START_ABS: insert_slot(item.timer_id, item.tick_value);
      ACT_START_REL: insert_slot(item.timer_id, tick_now + item.tick_value);
      ACT_STOP:      remove_slot(item.timer_id);
      default: ;
    endcase
    if (n == 0) begin
      batch[0] = snapshot(1'b0, '0);
      n = 1;
    end
    batch[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(batch[i]);
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      tick_now = '0;
      queue_len = 0;
      period = '1;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        queue_ids[i] = '0;
        slot_exp[i] = '0;
        slot_busy[i] = 1'b0;
      end
      expected_results.delete();
    end else begin
      if (cfg_we) period = cfg_wdata;
      // A result accepted here always belongs to an earlier transaction.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual fired %0b id %0d now 0x%0h",
                   $time, out_data.fired, out_data.expired_id, out_data.now_count);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("fired", 32'(want.fired), 32'(out_data.fired));
          check_field("expired_id", 32'(want.expired_id), 32'(out_data.expired_id));
          check_field("now_count", want.now_count, out_data.now_count);
          check_field("next_compare", 32'(want.next_compare), 32'(out_data.next_compare));
          check_field("compare_armed", 32'(want.compare_armed),
                      32'(out_data.compare_armed));
          check_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
      if (in_valid && in_ready) predict_action(in_data);
    end
    results_owed   <= expected_results.size();
    mismatch_count <= errors;
  end

endmodule

// File: test/tb_sorted_expiry_timer_queue_unit.sv
// Testbench top for sorted_expiry_timer_queue_unit: clock, reset, stimulus,
// result-side flow control and the verdict. Depends on setq_pkg, the block
// and timer_queue_checker, which does all prediction and comparison.
`timescale 1ns / 100ps

module tb_sorted_expiry_timer_queue_unit;
  import setq_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_we;
  logic [PERIOD_W-1:0] cfg_wdata;

  int                mismatch_count;
  int                results_owed;
  int                quiet_cycles;
  logic              calm;
  logic              hold_request;
  logic [TICK_W-1:0] ticks_sent;

  always #5 clk = ~clk;

  sorted_expiry_timer_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  timer_queue_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // Present one transaction and hold it until the block takes it.
  task automatic offer(input action_t act, input logic [ID_W-1:0] id,
                       input logic [TICK_W-1:0] value);
    in_item_t item;
    item.action     = act;
    item.timer_id   = id;
    item.tick_value = value;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == ACT_TICK) ticks_sent = ticks_sent + 1'b1;
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int                pick;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] value;
    pick  = $urandom_range(0, 99);
    id    = ID_W'($urandom_range(0, NUM_TIMERS - 1));
    value = $urandom;
    if (pick < 40) begin
      offer(ACT_TICK, id, value);
    end else if (pick < 65) begin
      // Mostly short delays so that timers expire within the run.
      if ($urandom_range(0, 7) != 0) value = $urandom_range(0, 12);
      offer(ACT_START_REL, id, value);
    end else if (pick < 82) begin
      if ($urandom_range(0, 5) != 0) value = ticks_sent + $urandom_range(0, 14) - 2;
      offer(ACT_START_ABS, id, value);
    end else begin
      offer(ACT_STOP, id, value);
    end
  endtask

  task automatic random_run(input int count);
    for (int i = 0; i < count; i++) begin
      send_random();
      maybe_gap();
    end
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_period(input logic [PERIOD_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    ticks_sent   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset period.
    offer(ACT_TICK, 3'd7, 32'hFFFF_FFFF);
    offer(ACT_STOP, 3'd5, 32'h0);
    offer(ACT_START_ABS, 3'd0, 32'd4);
    offer(ACT_START_REL, 3'd1, 32'd2);
    offer(ACT_START_REL, 3'd2, 32'd0);
    offer(ACT_START_ABS, 3'd3, 32'hFFFF_FFFF);
    offer(ACT_START_ABS, 3'd4, 32'h7FFF_FFFF);
    offer(ACT_START_REL, 3'd1, 32'd3);
    offer(ACT_START_ABS, 3'd5, 32'd4);
    offer(ACT_STOP, 3'd4, 32'h0);
    offer(ACT_START_REL, 3'd6, 32'h8000_0000);
    offer(ACT_START_REL, 3'd7, 32'd100000);
    repeat (4) offer(ACT_TICK, 3'd0, 32'h0);
    offer(ACT_STOP, 3'd6, 32'h0);
    offer(ACT_STOP, 3'd7, 32'h0);
    // All slots expire on the same tick.
    for (int i = 0; i < NUM_TIMERS; i++) offer(ACT_START_REL, ID_W'(i), 32'd1);
    offer(ACT_TICK, 3'd0, 32'h0);
    drain(4);

    set_period(16'd1);
    random_run(15);
    drain(4);

    set_period(16'd0);
    random_run(8);
    drain(4);

    // Hold the result side off while items keep coming, so the block backs up.
    set_period(16'hFFFF);
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) send_random();
    drain(4);
    random_run(10);
    drain(4);

    set_period(PERIOD_W'($urandom_range(2, 400)));
    random_run(19);
    drain(4);

    set_period(16'd16);
    calm = 1'b1;
    for (int i = 0; i < 19; i++) send_random();

    drain(40);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/setq_pkg.sv
sv/sorted_expiry_timer_queue_unit.sv
test/timer_queue_checker.sv
test/tb_sorted_expiry_timer_queue_unit.sv
